// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NCDF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define NCDF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define NCDF_ASSERT(lbl, clk, rstn, prop)
`define NCDF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/ncdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ncdf_pkg
// Shared types and constants for the normal CDF and inverse CDF block.
// ----------------------------------------------------------------------------
`default_nettype none
package ncdf_pkg;
  localparam int EXP_DEPTH_DEF = 256;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int TOL_W         = 16;
  localparam int LIM_W         = 6;
  localparam int PROB_W        = 25;
  localparam int Z_W           = 21;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd1;

  localparam logic [TOL_W-1:0]  TOL_RESET = 16'd17;
  localparam logic [LIM_W-1:0]  LIM_RESET = 6'd50;
  localparam logic [PROB_W-1:0] ONE_Q24   = 25'd16777216;

  typedef struct packed {
    logic                  start;
    logic signed [Z_W-1:0] z;
  } ncdf_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROB_W-1:0] cdf;
  } ncdf_rsp_t;

  // Horner coefficients of the erf polynomial in signed Q2.24, highest order first.
  function automatic logic signed [26:0] poly_coef(input logic [2:0] i);
    logic signed [26:0] c;
    case (i)
      3'd0:    c = 27'sd17807428;
      3'd1:    c = -27'sd24379845;
      3'd2:    c = 27'sd23847365;
      3'd3:    c = -27'sd4773063;
      3'd4:    c = 27'sd4275331;
      default: c = 27'sd0;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ncdf_cdf_unit.sv =====
// ----------------------------------------------------------------------------
// ncdf_cdf_unit
// Sequenced CDF evaluator: one shared 32x32 multiplier, a radix-2 divider
// for the reciprocal and constant exp tables with linear interpolation.
// ----------------------------------------------------------------------------
`default_nettype none
module ncdf_cdf_unit
  import ncdf_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ncdf_req_t req,
  output ncdf_rsp_t      rsp
);
  localparam int TW = $clog2(EXP_TABLE_DEPTH + 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_X_MUL   = 5'd1;
  localparam logic [4:0] S_X_POST  = 5'd2;
  localparam logic [4:0] S_PX_MUL  = 5'd3;
  localparam logic [4:0] S_PX_POST = 5'd4;
  localparam logic [4:0] S_DIV_INI = 5'd5;
  localparam logic [4:0] S_DIV     = 5'd6;
  localparam logic [4:0] S_U_MUL   = 5'd7;
  localparam logic [4:0] S_U_POST  = 5'd8;
  localparam logic [4:0] S_SC_MUL  = 5'd9;
  localparam logic [4:0] S_SC_POST = 5'd10;
  localparam logic [4:0] S_IP_MUL  = 5'd11;
  localparam logic [4:0] S_IP_POST = 5'd12;
  localparam logic [4:0] S_E_MUL   = 5'd13;
  localparam logic [4:0] S_E_POST  = 5'd14;
  localparam logic [4:0] S_H_MUL   = 5'd15;
  localparam logic [4:0] S_H_POST  = 5'd16;
  localparam logic [4:0] S_M_MUL   = 5'd17;
  localparam logic [4:0] S_M_POST  = 5'd18;

  // Table entries are exp(-k/depth) in Q0.30 from a 21-term series in Q.40.
  function automatic logic [63:0] frac_entry(input int k);
    logic [63:0] term;
    logic signed [63:0] sum;
    term = 64'd1 << 40;
    sum  = 64'sd1 <<< 40;
    for (int n = 1; n <= 20; n++) begin
      term = (term * 64'(k)) / 64'(EXP_TABLE_DEPTH * n);
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    return (64'(sum) + 64'd512) >> 10;
  endfunction

  function automatic logic [63:0] int_entry(input int n);
    logic [63:0] v;
    logic [63:0] f1;
    v  = 64'd1 << 30;
    f1 = frac_entry(EXP_TABLE_DEPTH);
    for (int i = 1; i <= n; i++) v = (v * f1 + (64'd1 << 29)) >> 30;
    return v;
  endfunction

  logic [30:0] frac_tab [0:EXP_TABLE_DEPTH];
  logic [30:0] int_tab  [0:31];

  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_frac
    assign frac_tab[k] = 31'(frac_entry(k));
  end
  // Entries past the last integer step read as zero, so exp underflows to zero.
  for (genvar n = 0; n < 32; n++) begin : g_int
    if (n < 24) begin : g_val
      assign int_tab[n] = 31'(int_entry(n));
    end else begin : g_zero
      assign int_tab[n] = 31'd0;
    end
  end

  logic [4:0]         state_r, state_nxt;
  logic [63:0]        prod_r;
  logic [31:0]        mul_a, mul_b;
  logic [20:0]        mag_r;
  logic               neg_r;
  logic [19:0]        x_r;
  logic [26:0]        den_r;
  logic [26:0]        drem_r;
  logic [24:0]        num_r;
  logic [24:0]        q_r;
  logic [4:0]         cnt_r;
  logic [7:0]         n_r;
  logic [31:0]        f_r;
  logic [30:0]        hi_r, lo_r;
  logic [31:0]        frem_r;
  logic [30:0]        interp_r;
  logic [30:0]        e_r;
  logic signed [26:0] h_r;
  logic               hneg_r;
  logic [2:0]         hcnt_r;
  logic [PROB_W-1:0]  cdf_r;
  logic               done_r;

  logic [63:0]        rnd16, rnd23, rnd29;
  logic [27:0]        r2;
  logic               ge;
  logic [49:0]        n_full;
  logic [TW-1:0]      idx;
  logic [26:0]        hmag;
  logic [26:0]        hq;
  logic signed [26:0] hs;
  logic signed [28:0] ysum;
  logic [PROB_W-1:0]  yv;
  logic [PROB_W:0]    pos;

  assign rnd16  = prod_r + 64'd32768;
  assign rnd23  = prod_r + (64'd1 << 23);
  assign rnd29  = prod_r + (64'd1 << 29);
  assign r2     = {drem_r, num_r[24]};
  assign ge     = r2 >= {1'b0, den_r};
  assign n_full = (50'd1 << 48) + 50'(den_r >> 1);
  assign idx    = prod_r[32 +: TW];
  assign hmag   = h_r[26] ? 27'(-h_r) : 27'(h_r);
  assign hq     = rnd23[50:24];
  assign hs     = hneg_r ? -$signed(hq) : $signed(hq);
  assign ysum   = $signed({4'b0, ONE_Q24}) - $signed({1'b0, rnd29[57:30]});
  assign yv     = ysum < 0 ? '0 : (ysum > $signed({4'b0, ONE_Q24}) ? ONE_Q24 :
                  PROB_W'(ysum));
  assign pos    = ({1'b0, ONE_Q24} + {1'b0, yv} + 26'd1) >> 1;

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_X_MUL: begin
        mul_a = 32'(mag_r);
        mul_b = 32'd46341;
      end
      S_PX_MUL: begin
        mul_a = 32'(x_r);
        mul_b = 32'd5496067;
      end
      S_U_MUL: begin
        mul_a = 32'(x_r);
        mul_b = 32'(x_r);
      end
      S_SC_MUL: begin
        mul_a = f_r;
        mul_b = 32'(EXP_TABLE_DEPTH);
      end
      S_IP_MUL: begin
        mul_a = hi_r > lo_r ? 32'(hi_r - lo_r) : 32'd0;
        mul_b = frem_r;
      end
      S_E_MUL: begin
        // An integer part of 24 or more gives exp(-u) = 0.
        mul_a = n_r < 8'd24 ? 32'(int_tab[n_r[4:0]]) : 32'd0;
        mul_b = 32'(interp_r);
      end
      S_H_MUL: begin
        mul_a = 32'(hmag);
        mul_b = 32'(q_r);
      end
      S_M_MUL: begin
        mul_a = h_r[26] ? 32'd0 : 32'(h_r);
        mul_b = 32'(e_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (req.start) state_nxt = S_X_MUL;
      S_X_MUL:   state_nxt = S_X_POST;
      S_X_POST:  state_nxt = S_PX_MUL;
      S_PX_MUL:  state_nxt = S_PX_POST;
      S_PX_POST: state_nxt = S_DIV_INI;
      S_DIV_INI: state_nxt = S_DIV;
      S_DIV:     if (cnt_r == 5'd24) state_nxt = S_U_MUL;
      S_U_MUL:   state_nxt = S_U_POST;
      S_U_POST:  state_nxt = S_SC_MUL;
      S_SC_MUL:  state_nxt = S_SC_POST;
      S_SC_POST: state_nxt = S_IP_MUL;
      S_IP_MUL:  state_nxt = S_IP_POST;
      S_IP_POST: state_nxt = S_E_MUL;
      S_E_MUL:   state_nxt = S_E_POST;
      S_E_POST:  state_nxt = S_H_MUL;
      S_H_MUL:   state_nxt = S_H_POST;
      S_H_POST:  state_nxt = hcnt_r == 3'd4 ? S_M_MUL : S_H_MUL;
      S_M_MUL:   state_nxt = S_M_POST;
      S_M_POST:  state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= state_r == S_M_POST;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        neg_r <= req.z[Z_W-1];
        mag_r <= req.z[Z_W-1] ? 21'(-req.z) : 21'(req.z);
      end
      S_X_POST:  x_r <= rnd16[35:16];
      S_PX_POST: den_r <= 27'd16777216 + rnd16[42:16];
      S_DIV_INI: begin
        drem_r <= 27'(n_full >> 25);
        num_r  <= n_full[24:0];
        cnt_r  <= '0;
      end
      S_DIV: begin
        drem_r <= ge ? 27'(r2 - {1'b0, den_r}) : r2[26:0];
        num_r  <= {num_r[23:0], 1'b0};
        q_r    <= {q_r[23:0], ge};
        cnt_r  <= cnt_r + 5'd1;
      end
      S_U_POST: begin
        n_r <= prod_r[39:32];
        f_r <= prod_r[31:0];
      end
      S_SC_POST: begin
        hi_r   <= frac_tab[idx];
        lo_r   <= frac_tab[TW'(idx + 1'b1)];
        frem_r <= prod_r[31:0];
      end
      S_IP_POST: interp_r <= hi_r - prod_r[62:32];
      S_E_POST: begin
        e_r    <= rnd29[60:30];
        h_r    <= poly_coef(3'd0);
        hcnt_r <= '0;
      end
      S_H_MUL:   hneg_r <= h_r[26];
      S_H_POST: begin
        h_r    <= hcnt_r == 3'd4 ? hs : hs + poly_coef(hcnt_r + 3'd1);
        hcnt_r <= hcnt_r + 3'd1;
      end
      S_M_POST:  cdf_r <= neg_r ? ONE_Q24 - pos[PROB_W-1:0] : pos[PROB_W-1:0];
      default: begin
      end
    endcase
  end

  assign rsp.busy = state_r != S_IDLE;
  assign rsp.done = done_r;
  assign rsp.cdf  = cdf_r;
endmodule
`default_nettype wire

// ===== hw/rtl/normal_cdf_and_inverse.sv =====
// ----------------------------------------------------------------------------
// normal_cdf_and_inverse
// Standard normal CDF of a Q5.16 score, or inverse CDF of a Q0.24 probability.
// ----------------------------------------------------------------------------
// The block takes one word at a time and is not ready while it works. A
// forward CDF starts the CDF unit and loads its result into the output
// register once the unit is done. The CDF unit's sequence is seven
// multiplies and five polynomial multiplies through one shared multiplier,
// each followed by a rounding state, plus a setup state and a 25-step divider
// for the reciprocal; the start request, the unit's done flag and the output
// load are each registered. An inverse CDF runs one CDF per bisection step,
// at most the iteration limit (50 after reset, up to 63; a limit of zero runs
// one step), and goes to its done state after the last step. Saturated and
// midpoint cases go straight to the done state when the word is taken. The
// next word can be taken in the cycle after the result is loaded; a result
// that the receiver has not yet taken holds the block until it is taken.
`default_nettype none
`include "assert_macros.svh"
module normal_cdf_and_inverse
  import ncdf_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_operation,
  input  wire logic signed [Z_W-1:0] in_z_value,
  input  wire logic [PROB_W-1:0]     in_prob_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PROB_W-1:0]          out_result_prob,
  output logic signed [Z_W-1:0]      out_result_z,
  output logic                       out_saturated,
  output logic                       out_converged
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CDF   = 3'd1;
  localparam logic [2:0] ST_BIS   = 3'd2;
  localparam logic [2:0] ST_BWAIT = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [20:0] SPAN_Q16 = 21'd1310720;

  logic [2:0]              state_r;
  logic [TOL_W-1:0]        tol_r;
  logic [LIM_W-1:0]        lim_r;
  logic [PROB_W-1:0]       p_r;
  logic [20:0]             lo_r, hi_r, mid_r;
  logic [LIM_W-1:0]        step_r;
  ncdf_req_t               req_r;
  ncdf_rsp_t               rsp;
  logic [PROB_W-1:0]       res_prob_r;
  logic signed [Z_W-1:0]   res_z_r;
  logic                    res_sat_r, res_conv_r;
  logic                    out_valid_r;

  logic signed [25:0]      half_d;
  logic [24:0]             half_abs;
  logic [21:0]             mid_sum;
  logic [20:0]             mid_nxt;
  logic signed [21:0]      mid_z;
  logic signed [21:0]      bis_z;
  logic signed [25:0]      cd;
  logic [24:0]             cd_abs;
  logic [LIM_W-1:0]        steps;
  logic [LIM_W-1:0]        step_nxt;
  logic                    start_nxt;
  logic                    out_load;

  ncdf_cdf_unit #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_cdf (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  assign half_d   = $signed({1'b0, in_prob_value}) - 26'sd8388608;
  assign half_abs = half_d < 0 ? 25'(-half_d) : 25'(half_d);
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_nxt  = mid_sum[21:1];
  assign mid_z    = $signed({1'b0, mid_nxt}) - 22'sd655360;
  assign bis_z    = $signed({1'b0, mid_r}) - 22'sd655360;
  assign cd       = $signed({1'b0, rsp.cdf}) - $signed({1'b0, p_r});
  assign cd_abs   = cd < 0 ? 25'(-cd) : 25'(cd);
  assign steps    = lim_r == '0 ? LIM_W'(1) : lim_r;
  assign step_nxt = step_r + 1'b1;

  assign start_nxt = (state_r == ST_IDLE && in_valid && !in_operation) ||
                     state_r == ST_BIS;
  // The result moves out only once the output register is free.
  assign out_load  = state_r == ST_DONE && (!out_valid_r || out_ready);

  assign in_ready = state_r == ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      lim_r <= LIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TOLERANCE:  tol_r <= cfg_data;
        REG_ITER_LIMIT: lim_r <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      req_r.start <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_r.start <= start_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            p_r        <= in_prob_value;
            res_prob_r <= '0;
            res_z_r    <= '0;
            res_sat_r  <= 1'b0;
            res_conv_r <= 1'b0;
            if (!in_operation) begin
              req_r.z     <= in_z_value;
              state_r     <= ST_CDF;
            end else if (in_prob_value == '0) begin
              res_z_r   <= -21'sd655360;
              res_sat_r <= 1'b1;
              state_r   <= ST_DONE;
            end else if (in_prob_value >= ONE_Q24) begin
              res_z_r   <= 21'sd655360;
              res_sat_r <= 1'b1;
              state_r   <= ST_DONE;
            end else if (half_abs < {9'd0, tol_r}) begin
              res_conv_r <= 1'b1;
              state_r    <= ST_DONE;
            end else begin
              lo_r    <= '0;
              hi_r    <= SPAN_Q16;
              step_r  <= '0;
              state_r <= ST_BIS;
            end
          end
        end
        ST_CDF: begin
          if (rsp.done) begin
            res_prob_r <= rsp.cdf;
            state_r    <= ST_DONE;
          end
        end
        ST_BIS: begin
          mid_r       <= mid_nxt;
          req_r.z     <= mid_z[Z_W-1:0];
          state_r     <= ST_BWAIT;
        end
        ST_BWAIT: begin
          if (rsp.done) begin
            res_z_r <= bis_z[Z_W-1:0];
            step_r  <= step_nxt;
            if (cd_abs < {9'd0, tol_r}) begin
              res_conv_r <= 1'b1;
              state_r    <= ST_DONE;
            end else begin
              if (rsp.cdf < p_r) lo_r <= mid_r;
              else hi_r <= mid_r;
              state_r <= step_nxt == steps ? ST_DONE : ST_BIS;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_result_prob <= res_prob_r;
            out_result_z    <= res_z_r;
            out_saturated   <= res_sat_r;
            out_converged   <= res_conv_r;
            state_r         <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  `NCDF_ASSERT(a_idle_unit_free, clk, rst_n, (in_ready |-> !rsp.busy))
  `NCDF_ASSERT(a_sat_not_conv, clk, rst_n, ((out_valid && out_saturated) |-> !out_converged))
  `NCDF_ASSERT(a_prob_range, clk, rst_n, (out_valid |-> (out_result_prob <= ONE_Q24)))
  `NCDF_ASSERT(a_bounds_order, clk, rst_n, ((state_r == ST_BWAIT) |-> (lo_r <= hi_r)))
endmodule
`default_nettype wire
